// ===== src/tods_pkg.sv =====
// Shared types, constants and the control store for the time-of-day clock.
// Used by tods_sequencer, tods_datapath and time_of_day_clock_serial_set.
// No dependencies.
package tods_pkg;

   localparam int LINE_DEPTH = 9;
   localparam int IDX_W      = $clog2(LINE_DEPTH);
   localparam int LEN_W      = $clog2(LINE_DEPTH + 1);
   localparam int STEP_W     = 5;

   localparam logic MODE_TICK = 1'b0;

   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [3:0] DIGIT_HI   = 4'h3;

   localparam logic [7:0] SEC_WRAP  = 8'd60;
   localparam logic [7:0] MIN_WRAP  = 8'd60;
   localparam logic [7:0] HOUR_WRAP = 8'd24;
   localparam logic [7:0] HUNDRED   = 8'd100;

   // hour/minute/second select
   localparam logic [1:0] UNIT_HOUR = 2'd0;
   localparam logic [1:0] UNIT_MIN  = 2'd1;
   localparam logic [1:0] UNIT_SEC  = 2'd2;

   // micro-operations
   localparam logic [3:0] OP_WAIT = 4'd0;
   localparam logic [3:0] OP_TICK = 4'd1;
   localparam logic [3:0] OP_HUND = 4'd2;
   localparam logic [3:0] OP_TENS = 4'd3;
   localparam logic [3:0] OP_ONES = 4'd4;
   localparam logic [3:0] OP_CHAR = 4'd5;
   localparam logic [3:0] OP_SEP  = 4'd6;
   localparam logic [3:0] OP_SKIP = 4'd7;
   localparam logic [3:0] OP_DIG1 = 4'd8;
   localparam logic [3:0] OP_DIG2 = 4'd9;
   localparam logic [3:0] OP_DONE = 4'd10;

   localparam logic [STEP_W-1:0] STEP_IDLE  = STEP_W'(0);
   localparam logic [STEP_W-1:0] STEP_PARSE = STEP_W'(14);
   localparam logic [STEP_W-1:0] STEP_DONE  = STEP_W'(18);

   typedef struct packed {
      logic       mode;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_char;
      logic       last_char;
   } rsp_type;

   typedef struct packed {
      logic [3:0]        op;
      logic [1:0]        unit;
      logic [7:0]        chr;
      logic              last;
      logic [STEP_W-1:0] target;
   } ctl_type;

   typedef struct packed {
      logic hold;
      logic taken;
   } stat_type;

   function automatic ctl_type mk(input logic [3:0] op, input logic [1:0] unit,
                                  input logic [7:0] chr, input logic last,
                                  input logic [STEP_W-1:0] target);
      ctl_type w;
      w.op     = op;
      w.unit   = unit;
      w.chr    = chr;
      w.last   = last;
      w.target = target;
      return w;
   endfunction

   // control store
   function automatic ctl_type ucode(input logic [STEP_W-1:0] step);
      ctl_type w;
      unique case (step)
         5'd0:    w = mk(OP_WAIT, UNIT_HOUR, 8'h00, 1'b0, STEP_PARSE);
         5'd1:    w = mk(OP_TICK, UNIT_HOUR, 8'h00, 1'b0, STEP_IDLE);
         5'd2:    w = mk(OP_HUND, UNIT_HOUR, 8'h00, 1'b0, STEP_IDLE);
         5'd3:    w = mk(OP_TENS, UNIT_HOUR, 8'h00, 1'b0, STEP_IDLE);
         5'd4:    w = mk(OP_ONES, UNIT_HOUR, 8'h00, 1'b0, STEP_IDLE);
         5'd5:    w = mk(OP_CHAR, UNIT_HOUR, CHAR_COLON, 1'b0, STEP_IDLE);
         5'd6:    w = mk(OP_HUND, UNIT_MIN, 8'h00, 1'b0, STEP_IDLE);
         5'd7:    w = mk(OP_TENS, UNIT_MIN, 8'h00, 1'b0, STEP_IDLE);
         5'd8:    w = mk(OP_ONES, UNIT_MIN, 8'h00, 1'b0, STEP_IDLE);
         5'd9:    w = mk(OP_CHAR, UNIT_MIN, CHAR_COLON, 1'b0, STEP_IDLE);
         5'd10:   w = mk(OP_HUND, UNIT_SEC, 8'h00, 1'b0, STEP_IDLE);
         5'd11:   w = mk(OP_TENS, UNIT_SEC, 8'h00, 1'b0, STEP_IDLE);
         5'd12:   w = mk(OP_ONES, UNIT_SEC, 8'h00, 1'b0, STEP_IDLE);
         5'd13:   w = mk(OP_CHAR, UNIT_SEC, CHAR_NL, 1'b1, STEP_IDLE);
         5'd14:   w = mk(OP_SEP,  UNIT_HOUR, 8'h00, 1'b0, STEP_DONE);
         5'd15:   w = mk(OP_SKIP, UNIT_HOUR, 8'h00, 1'b0, STEP_IDLE);
         5'd16:   w = mk(OP_DIG1, UNIT_HOUR, 8'h00, 1'b0, STEP_DONE);
         5'd17:   w = mk(OP_DIG2, UNIT_HOUR, 8'h00, 1'b0, STEP_PARSE);
         default: w = mk(OP_DONE, UNIT_HOUR, 8'h00, 1'b0, STEP_IDLE);
      endcase
      return w;
   endfunction

   // binary to three BCD digits, shift-and-add-3
   function automatic logic [11:0] to_bcd(input logic [7:0] v);
      logic [19:0] sh;
      sh = {12'd0, v};
      for (int i = 0; i < 8; i++) begin
         if (sh[11:8] >= 4'd5) begin
            sh[11:8] = sh[11:8] + 4'd3;
         end
         if (sh[15:12] >= 4'd5) begin
            sh[15:12] = sh[15:12] + 4'd3;
         end
         if (sh[19:16] >= 4'd5) begin
            sh[19:16] = sh[19:16] + 4'd3;
         end
         sh = {sh[18:0], 1'b0};
      end
      return sh[19:8];
   endfunction

endpackage

// ===== src/tods_sequencer.sv =====
// Micro-sequencer: step counter and control-store lookup with conditional jumps.
// Depends on tods_pkg.
module tods_sequencer (
   input  logic               clock,
   input  logic               reset,
   input  tods_pkg::stat_type stat,
   output tods_pkg::ctl_type  ctl
);

   logic [tods_pkg::STEP_W-1:0] pc_ff;
   logic [tods_pkg::STEP_W-1:0] pc_in;

   assign ctl = tods_pkg::ucode(pc_ff);

   always_comb begin
      priority if (stat.hold) begin
         pc_in = pc_ff;
      end else if (stat.taken) begin
         pc_in = ctl.target;
      end else begin
         pc_in = pc_ff + tods_pkg::STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= tods_pkg::STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ===== src/tods_datapath.sv =====
// Datapath: time counters, line store, parse pointer and the output register.
// Executes the control word from tods_sequencer. Depends on tods_pkg.
module tods_datapath (
   input  logic               clock,
   input  logic               reset,
   input  tods_pkg::ctl_type  ctl,
   output tods_pkg::stat_type stat,
   input  logic               req_valid,
   output logic               req_ready,
   input  tods_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output tods_pkg::rsp_type  rsp_data
);

   logic [7:0] hour_ff, hour_in;
   logic [7:0] min_ff, min_in;
   logic [7:0] sec_ff, sec_in;
   logic [7:0] line_store_ff [tods_pkg::LINE_DEPTH];
   logic [tods_pkg::LEN_W-1:0] len_ff, len_in;
   logic [tods_pkg::LEN_W-1:0] pos_ff, pos_in;
   logic [1:0] field_ff, field_in;
   logic [3:0] val_ff, val_in;
   logic rsp_valid_ff, rsp_valid_in;
   tods_pkg::rsp_type rsp_ff, rsp_in;

   logic store_we;
   logic req_accept;
   logic in_range;
   logic [7:0] cur_byte;
   logic cur_blank;
   logic cur_digit;
   logic [7:0] two_digit;
   logic [7:0] sel_val;
   logic [11:0] bcd;
   logic [7:0] s1, m1, h1;
   logic want_emit;
   logic can_load;
   tods_pkg::rsp_type emit_data;
   logic [7:0] field_val;

   assign req_ready  = (ctl.op == tods_pkg::OP_WAIT);
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign can_load   = !rsp_valid_ff || rsp_ready;

   assign in_range  = pos_ff < len_ff;
   assign cur_byte  = in_range ? line_store_ff[pos_ff[tods_pkg::IDX_W-1:0]] : 8'd0;
   assign cur_blank = (cur_byte == tods_pkg::CHAR_SPACE) ||
                      ((cur_byte >= tods_pkg::CHAR_TAB) && (cur_byte <= tods_pkg::CHAR_CR));
   assign cur_digit = (cur_byte >= tods_pkg::CHAR_ZERO) && (cur_byte <= tods_pkg::CHAR_NINE);
   assign two_digit = {4'd0, val_ff} * 8'd10 + {4'd0, cur_byte[3:0]};

   always_comb begin
      unique case (ctl.unit)
         tods_pkg::UNIT_HOUR: sel_val = hour_ff;
         tods_pkg::UNIT_MIN:  sel_val = min_ff;
         default:             sel_val = sec_ff;
      endcase
   end

   assign bcd = tods_pkg::to_bcd(sel_val);

   // wrap on exact equality only
   always_comb begin
      s1 = sec_ff + 8'd1;
      m1 = min_ff;
      h1 = hour_ff;
      if (s1 == tods_pkg::SEC_WRAP) begin
         s1 = 8'd0;
         m1 = min_ff + 8'd1;
      end
      if (m1 == tods_pkg::MIN_WRAP) begin
         m1 = 8'd0;
         h1 = hour_ff + 8'd1;
      end
      if (h1 == tods_pkg::HOUR_WRAP) begin
         h1 = 8'd0;
      end
   end

   always_comb begin
      hour_in      = hour_ff;
      min_in       = min_ff;
      sec_in       = sec_ff;
      len_in       = len_ff;
      pos_in       = pos_ff;
      field_in     = field_ff;
      val_in       = val_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      store_we     = 1'b0;
      stat         = '0;
      want_emit    = 1'b0;
      emit_data    = '0;
      field_val    = {4'd0, val_ff};

      unique case (ctl.op)
         tods_pkg::OP_WAIT: begin
            if (!req_accept) begin
               stat.hold = 1'b1;
            end else if (req_data.mode == tods_pkg::MODE_TICK) begin
               stat.hold = 1'b0;
            end else if ((req_data.rx_byte == tods_pkg::CHAR_NL) ||
                         (req_data.rx_byte == tods_pkg::CHAR_CR)) begin
               stat.taken = 1'b1;
               pos_in     = '0;
               field_in   = tods_pkg::UNIT_HOUR;
            end else begin
               stat.hold = 1'b1;
               if (len_ff < tods_pkg::LEN_W'(tods_pkg::LINE_DEPTH)) begin
                  store_we = 1'b1;
                  len_in   = len_ff + tods_pkg::LEN_W'(1);
               end
            end
         end
         tods_pkg::OP_TICK: begin
            sec_in  = s1;
            min_in  = m1;
            hour_in = h1;
         end
         tods_pkg::OP_HUND: begin
            want_emit = (sel_val >= tods_pkg::HUNDRED);
            emit_data = '{tx_char: {tods_pkg::DIGIT_HI, bcd[11:8]}, last_char: 1'b0};
         end
         tods_pkg::OP_TENS: begin
            want_emit = 1'b1;
            emit_data = '{tx_char: {tods_pkg::DIGIT_HI, bcd[7:4]}, last_char: 1'b0};
         end
         tods_pkg::OP_ONES: begin
            want_emit = 1'b1;
            emit_data = '{tx_char: {tods_pkg::DIGIT_HI, bcd[3:0]}, last_char: 1'b0};
         end
         tods_pkg::OP_CHAR: begin
            want_emit  = 1'b1;
            emit_data  = '{tx_char: ctl.chr, last_char: ctl.last};
            stat.taken = ctl.last;
         end
         tods_pkg::OP_SEP: begin
            if (field_ff != tods_pkg::UNIT_HOUR) begin
               if (!in_range || (cur_byte != tods_pkg::CHAR_DOT)) begin
                  stat.taken = 1'b1;
               end else begin
                  pos_in = pos_ff + tods_pkg::LEN_W'(1);
               end
            end
         end
         tods_pkg::OP_SKIP: begin
            if (in_range && cur_blank) begin
               stat.hold = 1'b1;
               pos_in    = pos_ff + tods_pkg::LEN_W'(1);
            end
         end
         tods_pkg::OP_DIG1: begin
            if (!in_range || !cur_digit) begin
               stat.taken = 1'b1;
            end else begin
               val_in = cur_byte[3:0];
               pos_in = pos_ff + tods_pkg::LEN_W'(1);
            end
         end
         tods_pkg::OP_DIG2: begin
            if (in_range && cur_digit) begin
               field_val = two_digit;
               pos_in    = pos_ff + tods_pkg::LEN_W'(1);
            end
            unique case (field_ff)
               tods_pkg::UNIT_HOUR: hour_in = field_val;
               tods_pkg::UNIT_MIN:  min_in  = field_val;
               default:             sec_in  = field_val;
            endcase
            field_in   = field_ff + 2'd1;
            stat.taken = (field_ff != tods_pkg::UNIT_SEC);
         end
         default: begin
            len_in     = '0;
            pos_in     = '0;
            field_in   = tods_pkg::UNIT_HOUR;
            stat.taken = 1'b1;
         end
      endcase

      if (want_emit) begin
         if (can_load) begin
            rsp_in       = emit_data;
            rsp_valid_in = 1'b1;
         end else begin
            stat.hold = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hour_ff      <= '0;
         min_ff       <= '0;
         sec_ff       <= '0;
         len_ff       <= '0;
         pos_ff       <= '0;
         field_ff     <= tods_pkg::UNIT_HOUR;
         rsp_valid_ff <= 1'b0;
      end else begin
         hour_ff      <= hour_in;
         min_ff       <= min_in;
         sec_ff       <= sec_in;
         len_ff       <= len_in;
         pos_ff       <= pos_in;
         field_ff     <= field_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      rsp_ff <= rsp_in;
      if (store_we) begin
         line_store_ff[len_ff[tods_pkg::IDX_W-1:0]] <= req_data.rx_byte;
      end
   end

endmodule

// ===== src/time_of_day_clock_serial_set.sv =====
// Top level of the time-of-day clock with serial set and report.
// Instantiates tods_sequencer and tods_datapath; depends on tods_pkg.
//
// Each request is a one-second tick (mode 0) or a received byte (mode 1). A tick
// advances seconds, minutes and hours (wrapping on exact match of 60, 60, 24)
// and then sends the time as "hh:mm:ss" plus newline, one character per
// response transfer, with last_char set on the newline; a count above 99 is
// sent with three digits. Ordinary bytes fill a LINE_DEPTH-byte line buffer,
// extra bytes are dropped. Carriage return or newline parses the buffer as
// "hh.mm.ss" (leading blanks skipped, one or two digits per field) and loads
// every field read before the first mismatch, then empties the buffer.
// Control is a 19-step microprogram; one step runs per cycle unless a step holds.
// A tick keeps the next request waiting until its newline is loaded, and longer
// while the response side stalls. A stored byte leaves the clock waiting for
// the next request. A line end keeps the next request waiting until parsing
// ends, longer for each blank skipped; a mismatch ends the parse sooner.
module time_of_day_clock_serial_set (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tods_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tods_pkg::rsp_type rsp_data
);

   tods_pkg::ctl_type  ctl;
   tods_pkg::stat_type stat;

   tods_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctl   (ctl)
   );

   tods_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .stat      (stat),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
